FILE: design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the serial RC frame decoder
// Frame marks, byte positions, channel geometry, controller state and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChBits   = 11;
  localparam int unsigned ChCount  = 16;
  localparam int unsigned ChIdxW   = $clog2(ChCount);
  localparam int unsigned MemAddrW = ChIdxW + 1;
  localparam int unsigned PosW     = 5;
  localparam int unsigned IssW     = ChIdxW + 1;
  // bits left over between bytes never exceed ChBits - 1
  localparam int unsigned AccW     = ChBits - 1;
  localparam int unsigned FullW    = AccW + ByteW;
  localparam int unsigned CntW     = $clog2(ChBits);
  localparam int unsigned SumW     = $clog2(FullW + 1);

  localparam logic [ByteW-1:0] StartMark = 8'h0F;
  localparam logic [ByteW-1:0] EndMark   = 8'h00;

  localparam logic [PosW-1:0] PosFirstData = 5'd1;
  localparam logic [PosW-1:0] PosLastData  = 5'd22;
  localparam logic [PosW-1:0] FlagPos      = 5'd23;
  localparam logic [PosW-1:0] EndPos       = 5'd24;

  localparam int unsigned FailsafeBit  = 3;
  localparam int unsigned FrameLostBit = 2;

  typedef enum logic {
    SFD_IDLE,
    SFD_READ
  } sfd_state_e;

  typedef struct packed {
    logic              clr_acc;   // byte seen while waiting for start
    logic              data_en;   // data byte to unpack
    logic              flag_en;   // flag byte
    logic              publish;   // good end byte: swap banks
    logic              rd_en;     // fetch one published channel
    logic [ChIdxW-1:0] rd_chan;
  } sfd_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
  } sfd_sts_t;

endpackage

FILE: design/sfd_in_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if: input channel of the frame decoder
// One word is either a received byte or a read request.
// ----------------------------------------------------------------------------
interface sfd_in_if import sfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

FILE: design/sfd_out_if.sv
// ----------------------------------------------------------------------------
// sfd_out_if: result channel of the frame decoder
// One word per channel of the published frame.
// ----------------------------------------------------------------------------
interface sfd_out_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChIdxW-1:0] channel_index;
  logic [ChBits-1:0] channel_value;
  logic              failsafe;
  logic              link_lost;
  logic              last;

  modport source (output valid, output channel_index, output channel_value,
                  output failsafe, output link_lost, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input failsafe, input link_lost, input last, output ready);
endinterface

FILE: design/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath: bit unpacker, two-bank channel memory and result register
// Gathers data bytes into 11-bit channels, writes each finished channel into
// the filling bank and reads the published bank out one channel a cycle while the result word is not stalled.
// ----------------------------------------------------------------------------
module sfd_datapath import sfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfd_cmd_t          cmd_i,
  input  logic [ByteW-1:0]  byte_value_i,
  output sfd_sts_t          sts_o,
  output logic [ChIdxW-1:0] channel_index_o,
  output logic [ChBits-1:0] channel_value_o,
  output logic              failsafe_o,
  output logic              link_lost_o,
  output logic              last_o
);

  logic [ChBits-1:0] mem [2**MemAddrW];

  logic              fill_bank_q;
  logic              pub_seen_q;
  logic [1:0]        flag_q [2];
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ChIdxW-1:0] wr_chan_q;
  logic [FullW-1:0]  full;
  logic [SumW-1:0]   sum;
  logic              wr_en;

  logic [ChIdxW-1:0] out_chan_q;
  logic [ChBits-1:0] rd_data_q;
  logic              fs_q, fl_q;

  assign sts_o.is_start = (byte_value_i == StartMark);
  assign sts_o.is_end   = (byte_value_i == EndMark);

  // new byte lands just above the bits still pending
  always_comb begin
    full  = FullW'(acc_q) | (FullW'(byte_value_i) << cnt_q);
    sum   = SumW'(cnt_q) + SumW'(ByteW);
    wr_en = cmd_i.data_en && (sum >= SumW'(ChBits));
    if (wr_en) begin
      acc_d = AccW'(full >> ChBits);
      cnt_d = CntW'(sum - SumW'(ChBits));
    end else begin
      acc_d = AccW'(full);
      cnt_d = CntW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_bank_q <= 1'b0;
      pub_seen_q  <= 1'b0;
      flag_q[0]   <= 2'b00;
      flag_q[1]   <= 2'b11;
      acc_q       <= '0;
      cnt_q       <= '0;
      wr_chan_q   <= '0;
    end else begin
      if (cmd_i.clr_acc) begin
        acc_q     <= '0;
        cnt_q     <= '0;
        wr_chan_q <= '0;
      end else if (cmd_i.data_en) begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        if (wr_en) begin
          wr_chan_q <= wr_chan_q + 1'b1;
        end
      end
      if (cmd_i.flag_en) begin
        flag_q[fill_bank_q] <= {byte_value_i[FailsafeBit], byte_value_i[FrameLostBit]};
      end
      if (cmd_i.publish) begin
        fill_bank_q <= ~fill_bank_q;
        pub_seen_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{fill_bank_q, wr_chan_q}] <= full[ChBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q  <= mem[{~fill_bank_q, cmd_i.rd_chan}];
      out_chan_q <= cmd_i.rd_chan;
      fs_q       <= flag_q[~fill_bank_q][1];
      fl_q       <= flag_q[~fill_bank_q][0];
    end
  end

  // before the first good frame the published bank reads as all zero
  assign channel_value_o = rd_data_q & {ChBits{pub_seen_q}};
  assign channel_index_o = out_chan_q;
  assign failsafe_o      = fs_q;
  assign link_lost_o     = fl_q;
  assign last_o          = (out_chan_q == ChIdxW'(ChCount - 1));

endmodule

FILE: design/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl: frame sequencer and read controller
// Tracks the byte position within a frame and issues one channel fetch a
// cycle during a read, holding back while the result word is stalled.
// ----------------------------------------------------------------------------
module sfd_ctrl import sfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sfd_sts_t sts_i,
  output sfd_cmd_t cmd_o
);

  sfd_state_e      state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [IssW-1:0] iss_q, iss_d;
  logic            out_valid_q, out_valid_d;
  logic            take, adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SFD_IDLE;
      pos_q       <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == SFD_IDLE);
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign adv         = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    iss_d         = iss_q;
    out_valid_d   = out_valid_q;
    cmd_o         = '0;
    cmd_o.rd_chan = iss_q[ChIdxW-1:0];
    unique case (state_q)
      SFD_IDLE: begin
        if (take && in_action_i) begin
          state_d = SFD_READ;
          iss_d   = '0;
        end else if (take) begin
          unique case (pos_q) inside
            [PosFirstData:PosLastData]: begin
              cmd_o.data_en = 1'b1;
              pos_d         = pos_q + 1'b1;
            end
            FlagPos: begin
              cmd_o.flag_en = 1'b1;
              pos_d         = EndPos;
            end
            EndPos: begin
              cmd_o.publish = sts_i.is_end;
              pos_d         = '0;
            end
            default: begin
              cmd_o.clr_acc = 1'b1;
              pos_d         = sts_i.is_start ? PosFirstData : '0;
            end
          endcase
        end
      end
      SFD_READ: begin
        if (adv) begin
          if (iss_q != IssW'(ChCount)) begin
            cmd_o.rd_en = 1'b1;
            out_valid_d = 1'b1;
            iss_d       = iss_q + 1'b1;
          end else begin
            out_valid_d = 1'b0;
            state_d     = SFD_IDLE;
          end
        end
      end
      default: begin
        state_d = SFD_IDLE;
      end
    endcase
  end

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q)
    else $error("result word pending while input is open");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= EndPos)
    else $error("frame position out of range");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_acc, cmd_o.data_en, cmd_o.flag_en, cmd_o.publish, cmd_o.rd_en}))
    else $error("more than one datapath command at once");

  a_fetch_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> out_valid_q)
    else $error("fetched channel not presented");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.rd_en)
    else $error("fetch overwrote a stalled result word");

endmodule

FILE: design/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core: 16-channel serial RC frame decoder
// Unpacks 25-byte frames into sixteen 11-bit channels in a double-buffered
// store and streams the latest good frame out on request.
// ----------------------------------------------------------------------------
//
//  channel | dir | word carries
//  --------+-----+----------------------------------------------------------
//  in_i    | in  | action (0 = serial byte, 1 = read), byte_value
//  out_o   | out | channel_index, channel_value, failsafe, link_lost, last
//
// A received byte is taken and gives no result.
// A read first fetches the first channel from the registered read port, then
// presents one word per cycle while out_o is not stalled, for all sixteen
// channels; in_i reopens in the cycle after the last word is taken.
// The input is closed for the whole of a read; each stall on out_o holds the
// word and delays the rest of the read.
// Reset waits for a start byte; no clearing pass. Until the first good frame
// the published channels read as zero with failsafe and link-lost set.
//
module sbus_frame_decoder_core import sfd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfd_in_if.sink         in_i,
  sfd_out_if.source      out_o
);

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  // Controller: frame position and read sequencing
  sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: unpacker, bank memory, flags and result register
  sfd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .byte_value_i    (in_i.byte_value),
    .sts_o           (sts),
    .channel_index_o (out_o.channel_index),
    .channel_value_o (out_o.channel_value),
    .failsafe_o      (out_o.failsafe),
    .link_lost_o     (out_o.link_lost),
    .last_o          (out_o.last)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the serial RC frame decoder
// Feeds received bytes and read requests into in_i. Frames are well formed,
// broken or interleaved with noise and reads. A local model of the frame
// unpacking predicts every channel word of each read. Each word on out_o is
// checked field by field against the oldest prediction, under several
// patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import sfd_pkg::*;

  // word kinds on the input channel
  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_READ = 1'b1
  } sfd_action_e;

  // one predicted channel word of a read
  typedef struct packed {
    logic [ChIdxW-1:0] index;
    logic [ChBits-1:0] value;
    logic              failsafe;
    logic              link_lost;
    logic              last;
  } chan_word_t;

  logic clk_i;
  logic rst_ni;

  sfd_in_if  in_if ();
  sfd_out_if out_if ();

  sbus_frame_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // --------------------------------------------------------------------------
  // Local model of the decoder: byte position, bank being filled, both
  // channel banks (bank b, channel c at b*16 + c) and both flag pairs.
  // --------------------------------------------------------------------------
  logic [PosW-1:0]   frame_pos;
  logic              fill_bank;
  logic [ChBits-1:0] chan_mem [2*ChCount];
  logic [1:0]        flag_mem [2];   // {failsafe, link_lost}

  chan_word_t pending_words [$];     // channel words still owed by the block

  int unsigned src_idle_pct;         // chance per cycle that the sender holds off
  int unsigned sink_stall_pct;       // chance per cycle that out_o is not ready
  int unsigned words_sent;
  int unsigned mismatches;

  // --------------------------------------------------------------------------
  // Clock, 10 time units
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Watchdog: far beyond the slowest legal run, even with heavy back-pressure
  // --------------------------------------------------------------------------
  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model update for one received byte
  // --------------------------------------------------------------------------
  function automatic void absorb_byte(logic [ByteW-1:0] b);
    int unsigned base;
    int unsigned n;
    int unsigned ch;
    base = int'(fill_bank) * ChCount;
    if (frame_pos == '0 || frame_pos > EndPos) begin
      // hunting for start: every byte wipes the bank being filled, flags kept
      frame_pos = (b == StartMark) ? PosFirstData : '0;
      for (int c = 0; c < ChCount; c++) chan_mem[base + c] = '0;
    end else if (frame_pos == EndPos) begin
      // good end byte swaps the banks; a bad one just drops the frame
      if (b == EndMark) fill_bank = ~fill_bank;
      frame_pos = '0;
    end else if (frame_pos == FlagPos) begin
      flag_mem[fill_bank] = {b[FailsafeBit], b[FrameLostBit]};
      frame_pos = EndPos;
    end else begin
      // data byte, LSB first into the 176-bit channel stream
      for (int i = 0; i < ByteW; i++) begin
        n  = (int'(frame_pos) - 1) * ByteW + i;
        ch = (n / ChBits) % ChCount;
        chan_mem[base + ch][n % ChBits] = chan_mem[base + ch][n % ChBits] | b[i];
      end
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  // Model of a read: sixteen words from the published bank, no state change
  function automatic void queue_read_words();
    chan_word_t w;
    logic       pub;
    pub = ~fill_bank;
    for (int c = 0; c < ChCount; c++) begin
      w.index     = c[ChIdxW-1:0];
      w.value     = chan_mem[int'(pub) * ChCount + c];
      w.failsafe  = flag_mem[pub][1];
      w.link_lost = flag_mem[pub][0];
      w.last      = (c == ChCount - 1);
      pending_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Send one word on in_i. Called just after a rising edge; valid is left
  // high afterwards so back-to-back words need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_word(input sfd_action_e act, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.byte_value <= b;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    if (act == ACT_READ) queue_read_words();
    else absorb_byte(b);
  endtask

  // byte with the extremes weighted up
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return ByteW'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure on out_o
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    chan_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, channel_index %0d",
                                  out_if.channel_index));
      end else begin
        want = pending_words.pop_front();
        if (out_if.channel_index !== want.index)
          report_mismatch($sformatf("channel_index got %0d want %0d",
                                    out_if.channel_index, want.index));
        if (out_if.channel_value !== want.value)
          report_mismatch($sformatf("ch %0d channel_value got %0d want %0d",
                                    want.index, out_if.channel_value, want.value));
        if (out_if.failsafe !== want.failsafe)
          report_mismatch($sformatf("ch %0d failsafe got %b want %b",
                                    want.index, out_if.failsafe, want.failsafe));
        if (out_if.link_lost !== want.link_lost)
          report_mismatch($sformatf("ch %0d link_lost got %b want %b",
                                    want.index, out_if.link_lost, want.link_lost));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("ch %0d last got %b want %b",
                                    want.index, out_if.last, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before any good frame: zero channels, both flags set
  task automatic test_power_on_read();
    send_word(ACT_READ, 8'hA5);
  endtask

  // Noise at both byte extremes while hunting, then a frame of all-ones data
  // with a flag byte that has every bit set except the two flags
  task automatic test_full_scale_frame();
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, StartMark);
    for (int i = 0; i < 22; i++) send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'hF3);
    send_word(ACT_BYTE, EndMark);
    send_word(ACT_READ, 8'h00);
  endtask

  // Mixed traffic: mostly whole frames with random content and the odd read
  // in the middle, plus noise, cut-short frames, bad end bytes and reads
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_words);
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    target         = words_sent + n_words;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // whole frame; cut short now and then, which desyncs until the end position is reached
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, 21) : 22;
        send_word(ACT_BYTE, StartMark);
        for (int i = 0; i < cut; i++) begin
          if ($urandom_range(19) == 0) send_word(ACT_READ, pick_byte());
          send_word(ACT_BYTE, pick_byte());
        end
        if (cut == 22) begin
          send_word(ACT_BYTE, pick_byte());
          if ($urandom_range(4) == 0)
            send_word(ACT_BYTE, ByteW'($urandom_range(1, 255)));
          else
            send_word(ACT_BYTE, EndMark);
          if ($urandom_range(1) == 0) send_word(ACT_READ, pick_byte());
        end
      end else if (pick < 80) begin
        send_word(ACT_BYTE, pick_byte());
      end else begin
        send_word(ACT_READ, pick_byte());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    words_sent     = 0;
    mismatches     = 0;
    frame_pos      = '0;
    fill_bank      = 1'b0;
    for (int i = 0; i < 2*ChCount; i++) chan_mem[i] = '0;
    flag_mem[0] = 2'b00;
    flag_mem[1] = 2'b11;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.action     <= ACT_BYTE;
    in_if.byte_value <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_read();
    test_full_scale_frame();

    // idling phases: none, sender only, receiver only, both; a phase runs
    // past its count to finish the frame in hand
    test_random_traffic(0, 0, 15);
    test_random_traffic(52, 0, 15);
    test_random_traffic(0, 52, 15);
    test_random_traffic(26, 26, 15);

    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    // a read closes out in the cycle after its last word is taken
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
